// ===== rtl/u8cp_pkg.sv =====
// u8cp_pkg: shared widths, byte masks and register codes for the utf-8 decoder
// used by utf8_code_point_decoder and its port checker; no dependencies
`default_nettype none

package u8cp_pkg;

  // stream field widths
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned CP_W       = 31;
  localparam int unsigned PEND_W     = 3;
  localparam int unsigned IN_DATA_W  = 8;
  localparam int unsigned OUT_DATA_W = 32;

  // configuration port
  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;

  // register index, taken from paddr bit 2
  typedef enum logic {
    REG_UNICODE_ENABLE = 1'b0
  } reg_idx_t;

  localparam logic UNICODE_ENABLE_RST = 1'b1;

  // byte classification masks
  localparam logic [BYTE_W-1:0] BYTE_TOP   = 8'h80;
  localparam logic [BYTE_W-1:0] BYTE_SECND = 8'h40;
  localparam logic [BYTE_W-1:0] CONT_BITS  = 8'h3F;

endpackage

`default_nettype wire

// ===== rtl/utf8_code_point_decoder.sv =====
// utf8_code_point_decoder: byte-stream utf-8 decoder (2 to 6 byte forms) with apb config
// depends on u8cp_pkg
`default_nettype none

// One byte is taken per clock: the byte and the decoder state (pending count,
// 31-bit accumulator) pass through a single priority decode into the next
// state and the result register, so a new byte is accepted every cycle while
// the output side takes its results. A finished code point appears on the
// output in the cycle after its last byte; bytes that make no result (lead
// and continuation bytes, dropped bytes) produce nothing.
// s_tready falls only while a result waits in the output register and the
// downstream side is stalled. unicode_enable (reset 1) selects decoding; with
// it cleared every byte comes out zero-extended and any open sequence is lost.
module utf8_code_point_decoder
  import u8cp_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  // input stream
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [IN_DATA_W-1:0]  s_tdata,   // [7:0] in_byte
  // output stream
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic [OUT_DATA_W-1:0]      m_tdata,   // [30:0] code_point, [31] zero
  // configuration port
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0]      prdata,
  output logic                       pready
);

  // state
  logic              unicode_enable;
  logic [PEND_W-1:0] bytes_pending, bytes_pending_next;
  logic [CP_W-1:0]   value_accumulator, value_accumulator_next;
  logic [CP_W-1:0]   code_point, code_point_next;
  logic              emit;

  logic              in_req;
  logic [BYTE_W-1:0] b;
  reg_idx_t          reg_idx;

  assign b      = s_tdata;
  assign in_req = s_tvalid && s_tready;

  // configuration access
  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      unicode_enable <= UNICODE_ENABLE_RST;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_idx)
        REG_UNICODE_ENABLE: unicode_enable <= pwdata[0];
        default:            unicode_enable <= unicode_enable;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_UNICODE_ENABLE: prdata = {{(APB_DATA_W-1){1'b0}}, unicode_enable};
      default:            prdata = '0;
    endcase
  end

  // per-byte decode
  always_comb begin
    bytes_pending_next     = bytes_pending;
    value_accumulator_next = value_accumulator;
    code_point_next        = {{(CP_W-BYTE_W){1'b0}}, b};
    emit                   = 1'b0;
    priority if (!unicode_enable || (b & BYTE_TOP) == '0) begin
      // pass-through or ascii: emitted, open sequence dropped
      bytes_pending_next     = '0;
      value_accumulator_next = {{(CP_W-BYTE_W){1'b0}}, b};
      emit                   = 1'b1;
    end else if (bytes_pending != '0) begin
      if ((b & BYTE_SECND) != '0) begin
        // lead, 0xfe or 0xff inside a sequence
        bytes_pending_next = '0;
      end else begin
        value_accumulator_next = {value_accumulator[CP_W-7:0], b[5:0]};
        bytes_pending_next     = bytes_pending - PEND_W'(1);
        code_point_next        = {value_accumulator[CP_W-7:0], b[5:0]};
        emit                   = (bytes_pending == PEND_W'(1));
      end
    end else begin
      // lead byte: count leading ones, keep the value bits
      priority casez (b)
        8'b110?_????: begin
          bytes_pending_next     = PEND_W'(1);
          value_accumulator_next = CP_W'(b & 8'h1F);
        end
        8'b1110_????: begin
          bytes_pending_next     = PEND_W'(2);
          value_accumulator_next = CP_W'(b & 8'h0F);
        end
        8'b1111_0???: begin
          bytes_pending_next     = PEND_W'(3);
          value_accumulator_next = CP_W'(b & 8'h07);
        end
        8'b1111_10??: begin
          bytes_pending_next     = PEND_W'(4);
          value_accumulator_next = CP_W'(b & 8'h03);
        end
        8'b1111_110?: begin
          bytes_pending_next     = PEND_W'(5);
          value_accumulator_next = CP_W'(b & 8'h01);
        end
        // stray continuation, 0xfe, 0xff: dropped
        default: ;
      endcase
    end
  end

  // decoder state update
  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_pending     <= '0;
      value_accumulator <= '0;
    end else if (in_req) begin
      bytes_pending     <= bytes_pending_next;
      value_accumulator <= value_accumulator_next;
    end
  end

  // output register
  assign s_tready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s_tready) begin
      m_tvalid <= in_req && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (in_req && emit) begin
      code_point <= code_point_next;
    end
  end

  assign m_tdata = {{(OUT_DATA_W-CP_W){1'b0}}, code_point};

endmodule

`default_nettype wire

// ===== rtl/u8cp_checker.sv =====
// u8cp_checker: port-level assertions for utf8_code_point_decoder, bound to the top level
// depends on u8cp_pkg
`default_nettype none

module u8cp_checker
  import u8cp_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  s_tvalid,
  input wire logic                  s_tready,
  input wire logic [IN_DATA_W-1:0]  s_tdata,
  input wire logic                  m_tvalid,
  input wire logic                  m_tready,
  input wire logic [OUT_DATA_W-1:0] m_tdata
);

  // stalled result holds its value
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  // no result straight after reset
  assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // an empty output register never blocks the input
  assert property (@(posedge clk) !m_tvalid |-> s_tready)
    else $error("input stalled with empty output");

  // ascii byte comes out unchanged in the next cycle, in either mode
  assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && !s_tdata[7] |=>
      m_tvalid && m_tdata == {{(OUT_DATA_W-IN_DATA_W){1'b0}}, $past(s_tdata)})
    else $error("ascii byte not passed through");

  // code points use 31 bits only
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !m_tdata[OUT_DATA_W-1])
    else $error("code point top bit set");

endmodule

bind utf8_code_point_decoder u8cp_checker u_u8cp_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire

// ===== verif/utf8_code_point_decoder_tb.sv =====
// utf8_code_point_decoder_tb: self-checking bench for the byte-stream utf-8 decoder
// drives bytes and apb writes, predicts each code point and compares it in order
// depends on u8cp_pkg and rtl/utf8_code_point_decoder.sv
module utf8_code_point_decoder_tb
  import u8cp_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned IDLE_LIMIT  = 2000;
  localparam int unsigned PHASE_BYTES = 300;
  localparam logic [APB_ADDR_W-1:0] ADDR_ENABLE = {REG_UNICODE_ENABLE, 2'b00};
  localparam logic [APB_ADDR_W-1:0] ADDR_UNUSED = 3'd4;

  // tracks decoder state and holds the code points still due
  class cp_tracker;
    bit          enable;
    logic [2:0]  pending;
    logic [30:0] acc;
    logic [30:0] due_points[$];
    int          errors;

    function new();
      enable  = UNICODE_ENABLE_RST;
      pending = '0;
      acc     = '0;
      errors  = 0;
    endfunction

    function void set_enable(bit v);
      enable = v;
    endfunction

    function int outstanding();
      return due_points.size();
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      errors++;
    endtask

    // next-state and result for one accepted byte
    function void take_byte(logic [7:0] b);
      logic [2:0] ones;
      logic [7:0] vmask;
      if (!enable) begin
        pending = '0;
        acc     = {23'b0, b};
        due_points.push_back(acc);
      end else if ((b & BYTE_TOP) == 8'h00) begin
        pending = '0;
        acc     = {23'b0, b};
        due_points.push_back(acc);
      end else if (pending != 0) begin
        if ((b & BYTE_SECND) != 8'h00) begin
          pending = '0;
        end else begin
          acc     = {acc[24:0], b[5:0]};
          pending = pending - 3'd1;
          if (pending == 0) due_points.push_back(acc);
        end
      end else begin
        // lead byte: count leading ones, 0xfe and 0xff are not leads
        casez (b)
          8'b110?????: ones = 3'd2;
          8'b1110????: ones = 3'd3;
          8'b11110???: ones = 3'd4;
          8'b111110??: ones = 3'd5;
          8'b1111110?: ones = 3'd6;
          default:     ones = 3'd0;
        endcase
        if (ones != 0) begin
          vmask   = 8'hFF >> (ones + 3'd1);
          acc     = {23'b0, b & vmask};
          pending = ones - 3'd1;
        end
      end
    endfunction

    task match_code_point(logic [31:0] d);
      logic [30:0] want;
      if (due_points.size() == 0) begin
        report($sformatf("unexpected code point %h", d));
      end else begin
        want = due_points.pop_front();
        if (d[30:0] !== want)
          report($sformatf("code_point %h, predicted %h", d[30:0], want));
        if (d[31] !== 1'b0)
          report($sformatf("tdata pad bit set in %h", d));
      end
    endtask
  endclass

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;   // [7:0] in_byte
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;   // [30:0] code_point, [31] zero
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  cp_tracker   tracker;
  logic [7:0]  stim_q[$];
  int          bytes_sent;
  bit          no_idle;

  utf8_code_point_decoder dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // known input levels from time zero
  initial begin
    tracker    = new();
    rst        = 1'b1;
    s_tvalid   = 1'b0;
    s_tdata    = '0;
    m_tready   = 1'b0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    bytes_sent = 0;
    no_idle    = 1'b0;
  end

  // downstream stalls at random
  initial begin
    forever begin
      @(negedge clk);
      m_tready <= no_idle || ($urandom_range(99) >= 11);
    end
  end

  // observe accepted requests on both streams
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) tracker.match_code_point(m_tdata);
    if (!rst && s_tvalid && s_tready) tracker.take_byte(s_tdata);
  end

  // watchdog on cycles with no accepted request
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable && pready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("utf8_code_point_decoder verification failed");
    $finish;
  end

  // all tasks start and end just after a falling edge
  task apb_write(logic [APB_ADDR_W-1:0] addr, logic [APB_DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (addr == ADDR_ENABLE) tracker.set_enable(data[0]);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  task apb_read_check();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= ADDR_ENABLE;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== {31'b0, tracker.enable})
      tracker.report($sformatf("prdata %h, register holds %0d", prdata, tracker.enable));
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  task send_byte(logic [7:0] b);
    while (!no_idle && $urandom_range(99) < 11) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    do @(posedge clk); while (!s_tready);
    bytes_sent++;
    no_idle = (bytes_sent >= 500) && (bytes_sent < 700);
    @(negedge clk);
  endtask

  task send_queued();
    while (stim_q.size() != 0) send_byte(stim_q.pop_front());
  endtask

  // idle the input and let the block settle before a register write
  task drain();
    s_tvalid <= 1'b0;
    while (tracker.outstanding() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task set_mode(logic [APB_ADDR_W-1:0] addr, logic [APB_DATA_W-1:0] data);
    drain();
    apb_write(addr, data);
    apb_read_check();
  endtask

  // lead byte of an n-byte form with random value bits, ascii for n of one
  function automatic logic [7:0] lead_for(int n);
    logic [7:0] r;
    r = 8'($urandom);
    if (n == 1) return r & 8'h7F;
    return (8'hFF << (8 - n)) | (r & (8'hFF >> (n + 1)));
  endfunction

  function automatic logic [7:0] cont_byte();
    logic [7:0] r;
    r = 8'($urandom);
    return BYTE_TOP | (r & CONT_BITS);
  endfunction

  // well-formed sequences mostly, then broken ones and noise
  function automatic void queue_random();
    int r;
    int n;
    int k;
    r = $urandom_range(99);
    if (r < 70) begin
      n = $urandom_range(6, 1);
      stim_q.push_back(lead_for(n));
      for (int i = 1; i < n; i++) stim_q.push_back(cont_byte());
    end else if (r < 85) begin
      n = $urandom_range(6, 2);
      k = $urandom_range(n - 1, 1);
      stim_q.push_back(lead_for(n));
      for (int i = 1; i < k; i++) stim_q.push_back(cont_byte());
      case ($urandom_range(3))
        0:       stim_q.push_back(lead_for(1));
        1:       stim_q.push_back(lead_for($urandom_range(6, 2)));
        2:       stim_q.push_back(8'hFE | 8'($urandom_range(1)));
        default: stim_q.push_back(8'($urandom));
      endcase
    end else begin
      stim_q.push_back(8'($urandom));
    end
  endfunction

  task random_phase();
    int start;
    start = bytes_sent;
    while (bytes_sent - start < PHASE_BYTES) begin
      queue_random();
      send_queued();
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    apb_read_check();
    set_mode(ADDR_ENABLE, 32'h0000_0001);

    // ascii extremes, overlong pair, smallest 5-byte form, largest 6-byte form
    stim_q = '{8'h00, 8'h7F, 8'hC0, 8'h80,
               8'hF8, 8'h88, 8'h80, 8'h80, 8'h80,
               8'hFD, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 8'hBF};
    // ascii breaks a sequence, lead inside a sequence, then a stray continuation
    stim_q.push_back(8'hE2);
    stim_q.push_back(8'h41);
    stim_q.push_back(8'hF0);
    stim_q.push_back(8'hC2);
    stim_q.push_back(8'h80);
    // 0xfe alone, 0xff inside a sequence, then a sequence left open
    stim_q.push_back(8'hFE);
    stim_q.push_back(8'hE1);
    stim_q.push_back(8'hFF);
    stim_q.push_back(8'hE2);
    send_queued();

    // pass-through drops the open sequence, only bit 0 of the write counts
    set_mode(ADDR_ENABLE, 32'hFFFF_FFFE);
    stim_q = '{8'h82, 8'hFF, 8'h00};
    send_queued();
    set_mode(ADDR_ENABLE, 32'hFFFF_FFFF);
    stim_q = '{8'h80, 8'hC3, 8'hBF};
    send_queued();
    // write to an unused address must leave decoding on
    set_mode(ADDR_UNUSED, 32'h0000_0000);
    stim_q = '{8'hE2, 8'h82, 8'hAC};
    send_queued();

    // random phases over several settings
    random_phase();
    set_mode(ADDR_ENABLE, 32'h0000_0002);
    random_phase();
    set_mode(ADDR_ENABLE, $urandom | 32'h1);
    random_phase();
    set_mode(ADDR_UNUSED, $urandom & 32'hFFFF_FFFE);
    random_phase();

    // wait for the last code points, then settle
    s_tvalid <= 1'b0;
    while (tracker.outstanding() != 0) @(negedge clk);
    repeat (8) @(posedge clk);
    if (tracker.outstanding() != 0)
      tracker.report($sformatf("%0d code points never arrived", tracker.outstanding()));
    if (tracker.errors == 0) begin
      $display("utf8_code_point_decoder verification clean");
    end else begin
      $display("utf8_code_point_decoder verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/u8cp_pkg.sv
rtl/utf8_code_point_decoder.sv
rtl/u8cp_checker.sv
verif/utf8_code_point_decoder_tb.sv
